### sv/gyro_frame_parser_unit_macros.svh
// assertion macros for the gyro frame parser unit
// used by the top level; needs i_clk and i_rst_n in scope
`ifndef GYRO_FRAME_PARSER_UNIT_MACROS_SVH
`define GYRO_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gfp_pkg.sv
// shared types and constants for the gyro frame parser
// no dependencies
`default_nettype none
package gfp_pkg;

    localparam int          PAYLOAD_BYTES = 9;
    localparam int          IDX_W         = 4;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

    localparam logic [7:0]  HDR_BYTE   = 8'h55;
    localparam logic [7:0]  TYPE_RATE  = 8'h52;
    localparam logic [7:0]  TYPE_ANGLE = 8'h53;

    localparam logic        KIND_RATE  = 1'b0;
    localparam logic        KIND_ANGLE = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_RATE,
        PH_ANGLE
    } t_phase;

    // one completed frame: kind, payload bytes 2..7 and the checksum byte
    typedef struct packed {
        logic       kind;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        logic [7:0] chk;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

### sv/gfp_front.sv
// front end: header hunt, type decode and payload capture
// depends on gfp_pkg
`default_nettype none
module gfp_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [7:0]          i_rx_byte,
    input  wire gfp_pkg::t_q_status  i_q_status,
    output logic                     o_push,
    output gfp_pkg::t_frame          o_frame
);

    gfp_pkg::t_phase                 r_phase;
    gfp_pkg::t_phase                 n_phase;
    logic [gfp_pkg::IDX_W-1:0]       r_index;
    logic [gfp_pkg::IDX_W-1:0]       n_index;
    logic [7:0]                      r_store [2:7];
    logic                            w_in_payload;
    logic                            w_last;
    logic                            w_accept;

    assign w_in_payload = (r_phase == gfp_pkg::PH_RATE) || (r_phase == gfp_pkg::PH_ANGLE);
    assign w_last       = w_in_payload && (r_index == gfp_pkg::IDX_LAST);
    assign o_ready      = !(w_last && i_q_status.full);
    assign w_accept     = i_valid && o_ready;
    assign o_push       = w_accept && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gfp_pkg::PH_HUNT;
            r_index <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_index <= n_index;
        end
    end

    always_comb begin
        n_phase = gfp_pkg::PH_HUNT;
        n_index = '0;
        case (r_phase)
            gfp_pkg::PH_TYPE: begin
                if (i_rx_byte == gfp_pkg::TYPE_RATE) begin
                    n_phase = gfp_pkg::PH_RATE;
                end else if (i_rx_byte == gfp_pkg::TYPE_ANGLE) begin
                    n_phase = gfp_pkg::PH_ANGLE;
                end
            end
            gfp_pkg::PH_RATE, gfp_pkg::PH_ANGLE: begin
                if (!w_last) begin
                    n_phase = r_phase;
                    n_index = r_index + gfp_pkg::IDX_W'(1);
                end
            end
            default: begin
                if (i_rx_byte == gfp_pkg::HDR_BYTE) begin
                    n_phase = gfp_pkg::PH_TYPE;
                end
            end
        endcase
    end

    // payload capture, only bytes that feed a result are kept
    always_ff @(posedge i_clk) begin
        for (int i = 2; i <= 7; i++) begin
            if (w_accept && w_in_payload && (r_index == gfp_pkg::IDX_W'(i))) begin
                r_store[i] <= i_rx_byte;
            end
        end
    end

    always_comb begin
        o_frame.kind = (r_phase == gfp_pkg::PH_ANGLE) ? gfp_pkg::KIND_ANGLE
                                                      : gfp_pkg::KIND_RATE;
        o_frame.b2   = r_store[2];
        o_frame.b3   = r_store[3];
        o_frame.b4   = r_store[4];
        o_frame.b5   = r_store[5];
        o_frame.b6   = r_store[6];
        o_frame.b7   = r_store[7];
        o_frame.chk  = i_rx_byte;
    end

endmodule
`default_nettype wire

### sv/gfp_queue.sv
// small frame queue between front and back end
// depends on gfp_pkg
`default_nettype none
module gfp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire gfp_pkg::t_frame     i_frame,
    input  wire logic                i_pop,
    output gfp_pkg::t_frame          o_frame,
    output gfp_pkg::t_q_status       o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gfp_pkg::t_frame  r_slot [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_frame        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_frame;
        end
    end

endmodule
`default_nettype wire

### sv/gfp_back.sv
// back end: checksum, raw word, heading and output register
// depends on gfp_pkg
`default_nettype none
module gfp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gfp_pkg::t_frame     i_frame,
    input  wire gfp_pkg::t_q_status  i_q_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_frame_kind,
    output logic signed [15:0]       o_raw_value,
    output logic [15:0]              o_heading,
    output logic                     o_checksum_ok
);

    logic               r_valid;
    logic               r_kind;
    logic signed [15:0] r_raw;
    logic [15:0]        r_heading;
    logic               r_chk_ok;
    logic [7:0]         w_sum;
    logic [15:0]        w_word;
    logic [15:0]        w_heading;

    assign o_pop  = !i_q_status.empty && (!r_valid || i_ready);
    assign w_word = {i_frame.b5, i_frame.b4};

    always_comb begin
        if (i_frame.kind == gfp_pkg::KIND_ANGLE) begin
            w_sum = gfp_pkg::HDR_BYTE + gfp_pkg::TYPE_ANGLE + i_frame.b4 + i_frame.b5
                  + i_frame.b6 + i_frame.b7;
            w_heading = 16'd0 - w_word;
        end else begin
            w_sum = gfp_pkg::HDR_BYTE + gfp_pkg::TYPE_RATE + i_frame.b2 + i_frame.b3
                  + i_frame.b4 + i_frame.b5;
            w_heading = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_frame.kind;
            r_raw     <= w_word;
            r_heading <= w_heading;
            r_chk_ok  <= (w_sum == i_frame.chk);
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_kind  = r_kind;
    assign o_raw_value   = r_raw;
    assign o_heading     = r_heading;
    assign o_checksum_ok = r_chk_ok;

endmodule
`default_nettype wire

### sv/gyro_frame_parser_unit.sv
// gyro frame parser top: front end, frame queue, back end
// one byte beat accepted per cycle unless stalled; a frame is 11 beats (header, type, 9 payload)
// the last payload beat writes the frame into the queue; the output register loads it when the output is free
// input stalls only on a last payload beat while the frame queue is full
// synchronous active-low reset returns to header search and empties queue and output
`default_nettype none
`include "gyro_frame_parser_unit_macros.svh"
module gyro_frame_parser_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_frame_kind,
    output logic signed [15:0] o_raw_value,
    output logic [15:0]        o_heading,
    output logic               o_checksum_ok
);

    gfp_pkg::t_frame    w_push_frame;
    gfp_pkg::t_frame    w_head_frame;
    gfp_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    gfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_frame    (w_push_frame)
    );

    gfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_frame  (w_push_frame),
        .i_pop    (w_pop),
        .o_frame  (w_head_frame),
        .o_status (w_q_status)
    );

    gfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_head_frame),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_kind  (o_frame_kind),
        .o_raw_value   (o_raw_value),
        .o_heading     (o_heading),
        .o_checksum_ok (o_checksum_ok)
    );

    `GFP_ASSERT_NOW(a_push_on_beat, w_push, i_valid && o_ready, "queue push without input beat")
    `GFP_ASSERT_NOW(a_no_overflow, w_push, !w_q_status.full, "frame pushed into full queue")
    `GFP_ASSERT_NOW(a_rise_after_pop, $rose(o_valid), $past(w_pop), "result without queue pop")
    `GFP_ASSERT_NEXT(a_pop_gives_result, w_pop, o_valid, "queue pop did not load result")

endmodule
`default_nettype wire
